>>> design/phz_pkg.sv
`default_nettype none

package phz_pkg;

    localparam int COORD_W   = 24;
    localparam int LEN_W     = 23;
    localparam int BIN_W     = 10;
    localparam int COUNT_W   = 32;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    // z - ref plus box length needs 26 bits signed; magnitude fits 25
    localparam int DIFF_W    = COORD_W + 2;
    localparam int MAG_W     = COORD_W + 1;
    localparam int DVS_W     = LEN_W + BIN_W - 1;
    localparam int STEP_W    = 4;

    localparam logic [OP_W-1:0] OP_SET_PLATE = 2'd0;
    localparam logic [OP_W-1:0] OP_SAMPLE    = 2'd1;
    localparam logic [OP_W-1:0] OP_READ      = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_READ     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_BIN  = 2'd2;

    localparam logic [LEN_W-1:0] BOX_LEN_RST   = 23'd655360;
    localparam logic [LEN_W-1:0] BIN_WIDTH_RST = 23'd655;
    localparam logic [BIN_W-1:0] LAST_BIN_RST  = 10'd1000;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [COORD_W-1:0] plate_z_first;
        logic signed [COORD_W-1:0] plate_z_second;
        logic signed [COORD_W-1:0] sample_z;
        logic [BIN_W-1:0]          read_bin;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BIN_W-1:0]    bin_out;
        logic [COUNT_W-1:0]  count_out;
    } t_out_item;

    typedef struct packed {
        logic             done;
        logic             ok;
        logic [BIN_W-1:0] bin;
    } t_bin_res;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RESULT
    } t_state;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WRAP,
        PH_ABS,
        PH_CHK,
        PH_DIV,
        PH_DONE
    } t_bin_phase;

endpackage

`default_nettype wire

>>> design/phz_binner.sv
`default_nettype none

module phz_binner
    import phz_pkg::*;
#(
    parameter int NUM_BINS = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  wire signed [COORD_W-1:0] i_sample_z,
    input  wire signed [COORD_W-1:0] i_sheet_ref,
    input  wire [LEN_W-1:0]          i_box_len,
    input  wire [LEN_W-1:0]          i_bin_width,
    input  wire [BIN_W-1:0]          i_last_bin,
    output t_bin_res                 o_res
);

    t_bin_phase r_phase, n_phase;

    logic signed [DIFF_W-1:0] r_diff;
    logic [MAG_W-1:0]         r_rem;
    logic [DVS_W-1:0]         r_dvs;
    logic [BIN_W-1:0]         r_q;
    logic [STEP_W-1:0]        r_cnt;
    logic                     r_neg;
    logic                     r_ovf;

    logic                     last_step;
    logic                     take;
    logic [DIFF_W-1:0]        abs_diff;
    logic                     in_range;

    assign last_step = (r_cnt == STEP_W'(BIN_W - 1));
    assign take      = ({{(DVS_W-MAG_W){1'b0}}, r_rem} >= r_dvs);
    assign abs_diff  = r_diff[DIFF_W-1] ? DIFF_W'(-r_diff) : DIFF_W'(r_diff);

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: if (i_start) n_phase = PH_WRAP;
            PH_WRAP: n_phase = PH_ABS;
            PH_ABS:  n_phase = PH_CHK;
            PH_CHK:  n_phase = PH_DIV;
            PH_DIV:  if (last_step) n_phase = PH_DONE;
            PH_DONE: n_phase = PH_IDLE;
            default: n_phase = PH_IDLE;
        endcase
    end

    // a negative offset only lands in bin 0 when its quotient truncates to zero
    always_comb begin
        in_range = 1'b0;
        if (!r_ovf) begin
            if (r_neg) begin
                in_range = (r_q == '0);
            end else begin
                in_range = (r_q <= i_last_bin) && (32'(r_q) < 32'(NUM_BINS));
            end
        end
        o_res.done = (r_phase == PH_DONE);
        o_res.ok   = in_range;
        o_res.bin  = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    r_diff <= DIFF_W'(i_sample_z) - DIFF_W'(i_sheet_ref);
                end
            end
            PH_WRAP: begin
                if (r_diff[DIFF_W-1]) begin
                    r_diff <= r_diff + $signed({{(DIFF_W-LEN_W){1'b0}}, i_box_len});
                end
            end
            PH_ABS: begin
                r_neg <= r_diff[DIFF_W-1];
                r_rem <= abs_diff[MAG_W-1:0];
            end
            PH_CHK: begin
                // quotient wider than BIN_W bits is out of range anyway
                r_ovf <= ({{(DVS_W+1-MAG_W){1'b0}}, r_rem} >= {i_bin_width, {BIN_W{1'b0}}});
                r_dvs <= {i_bin_width, {(BIN_W-1){1'b0}}};
                r_cnt <= '0;
                r_q   <= '0;
            end
            PH_DIV: begin
                if (take) begin
                    r_rem <= MAG_W'({{(DVS_W-MAG_W){1'b0}}, r_rem} - r_dvs);
                end
                r_q   <= {r_q[BIN_W-2:0], take};
                r_dvs <= r_dvs >> 1;
                r_cnt <= r_cnt + STEP_W'(1);
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/phz_hist_ram.sv
`default_nettype none

module phz_hist_ram
    import phz_pkg::*;
#(
    parameter int NUM_BINS = 1024,
    parameter int AW       = 10
) (
    input  wire                i_clk,
    input  wire                i_rd_en,
    input  wire [AW-1:0]       i_rd_addr,
    output logic [COUNT_W-1:0] o_rd_data,
    input  wire                i_wr_en,
    input  wire [AW-1:0]       i_wr_addr,
    input  wire [COUNT_W-1:0]  i_wr_data
);

    logic [COUNT_W-1:0] r_mem [NUM_BINS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> design/periodic_z_density_histogram.sv
// Periodic z density histogram.
// Input channel (i_in_valid / o_in_ready, i_in_item) takes one beat per
// operation: set plate reference, add sample or read bin. Every input beat
// gives exactly one output beat on o_out_valid / i_out_ready, o_out_item.
// Items are handled one at a time. Set plate, read and the unused code go
// from the accepted beat straight to the result step; a sample first runs
// the iterative divider (offset, wrap, magnitude, range check, one
// quotient bit per cycle for BIN_W bits) followed by the histogram
// read-modify-write on the single-port-per-direction count memory.
// The result sits in an output register; the next input beat is taken as
// soon as it is loaded, even if the receiver has not taken it yet. When the
// receiver stalls with the output register still full, the next result waits
// in its final step and input stays blocked.
// After reset the count memory is zeroed by a sweep over all NUM_BINS entries,
// one entry per cycle, during which no input is taken. Configuration writes
// (i_cfg_valid, o_cfg_ready always high) are taken at any time and must
// only be issued while no item is in flight.
`default_nettype none

module periodic_z_density_histogram
    import phz_pkg::*;
#(
    parameter int NUM_BINS = 1024
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output t_out_item            o_out_item,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [LEN_W-1:0]      i_cfg_data
);

    localparam int AW = $clog2(NUM_BINS);

    t_state r_state, n_state;

    logic [LEN_W-1:0]          r_box_len;
    logic [LEN_W-1:0]          r_bin_width;
    logic [BIN_W-1:0]          r_last_bin;
    logic signed [COORD_W-1:0] r_sheet_ref;
    logic [AW-1:0]             r_clr_addr;
    t_in_item                  r_item;
    logic                      r_ok;
    logic [BIN_W-1:0]          r_bin;
    logic                      r_rd_oob;
    t_out_item                 r_out;
    logic                      r_out_valid;

    t_bin_res           bres;
    logic               accept;
    logic               out_free;
    logic               clr_last;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [COUNT_W-1:0] rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [COUNT_W-1:0] wr_data;
    logic               load_out;
    logic               set_ref;
    t_out_item          n_out;
    logic [COUNT_W-1:0] inc_count;
    logic [31:0]        in_bin_ext;
    logic [31:0]        res_bin_ext;
    logic [31:0]        item_bin_ext;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_out_item   = r_out;
    assign accept       = i_in_valid && o_in_ready;
    assign out_free     = !r_out_valid || i_out_ready;
    assign clr_last     = (r_clr_addr == AW'(NUM_BINS - 1));
    assign in_bin_ext   = 32'(i_in_item.read_bin);
    assign res_bin_ext  = 32'(bres.bin);
    assign item_bin_ext = 32'(r_bin);
    assign inc_count    = (rd_data == '1) ? rd_data : rd_data + COUNT_W'(1);

    phz_binner #(
        .NUM_BINS (NUM_BINS)
    ) u_binner (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept && (i_in_item.operation == OP_SAMPLE)),
        .i_sample_z  (i_in_item.sample_z),
        .i_sheet_ref (r_sheet_ref),
        .i_box_len   (r_box_len),
        .i_bin_width (r_bin_width),
        .i_last_bin  (r_last_bin),
        .o_res       (bres)
    );

    phz_hist_ram #(
        .NUM_BINS (NUM_BINS),
        .AW       (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (clr_last) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_in_item.operation == OP_SAMPLE) ? S_DIV : S_RESULT;
                end
            end
            S_DIV:    if (bres.done) n_state = S_RESULT;
            S_RESULT: if (out_free) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = in_bin_ext[AW-1:0];
        wr_en    = 1'b0;
        wr_addr  = r_clr_addr;
        wr_data  = '0;
        load_out = 1'b0;
        set_ref  = 1'b0;
        n_out    = '0;
        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
            end
            S_IDLE: begin
                rd_en = accept && (i_in_item.operation == OP_READ);
            end
            S_DIV: begin
                rd_en   = bres.done && bres.ok;
                rd_addr = res_bin_ext[AW-1:0];
            end
            S_RESULT: begin
                load_out = out_free;
                unique case (r_item.operation)
                    OP_SET_PLATE: begin
                        if ($signed(r_item.plate_z_first) > $signed(r_item.plate_z_second)) begin
                            n_out.status = ST_MISMATCH;
                        end else begin
                            set_ref = out_free;
                        end
                    end
                    OP_SAMPLE: begin
                        if (r_ok) begin
                            wr_en           = out_free;
                            wr_addr         = item_bin_ext[AW-1:0];
                            wr_data         = inc_count;
                            n_out.bin_out   = r_bin;
                            n_out.count_out = inc_count;
                        end else begin
                            n_out.status = ST_RANGE;
                        end
                    end
                    OP_READ: begin
                        n_out.status    = ST_READ;
                        n_out.bin_out   = r_item.read_bin;
                        n_out.count_out = r_rd_oob ? '0 : rd_data;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_sheet_ref <= '0;
            r_box_len   <= BOX_LEN_RST;
            r_bin_width <= BIN_WIDTH_RST;
            r_last_bin  <= LAST_BIN_RST;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (set_ref) begin
                r_sheet_ref <= r_item.plate_z_first;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_BOX_LEN:   r_box_len   <= i_cfg_data;
                    CFG_BIN_WIDTH: r_bin_width <= i_cfg_data;
                    CFG_LAST_BIN:  r_last_bin  <= i_cfg_data[BIN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item   <= i_in_item;
            r_rd_oob <= (in_bin_ext >= 32'(NUM_BINS));
        end
        if (bres.done) begin
            r_ok  <= bres.ok;
            r_bin <= bres.bin;
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

>>> design/phz_checker.sv
`default_nettype none

module phz_checker
    import phz_pkg::*;
(
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_ready,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input t_out_item           o_out_item,
    input wire                 i_cfg_valid,
    input wire                 o_cfg_ready
);

    // reset starts the clearing sweep and empties the output register
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("input open or result pending right after reset");

    // one item in flight: input closes after every accepted beat
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while one is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result beat changed or dropped");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == ST_MISMATCH || o_out_item.status == ST_RANGE)
        |-> o_out_item.bin_out == '0 && o_out_item.count_out == '0)
        else $error("error result carries a bin or count");

    a_cfg_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write refused");

endmodule

bind periodic_z_density_histogram phz_checker u_phz_checker (.*);

`default_nettype wire

>>> dv/phz_density_checker.sv
`timescale 1ns / 1ps

module phz_density_checker
    import phz_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_ready,
    input  t_in_item            i_in_item,
    input  wire                 i_out_valid,
    input  wire                 i_out_ready,
    input  t_out_item           i_out_item,
    input  wire                 i_cfg_valid,
    input  wire                 i_cfg_ready,
    input  wire [CFG_IDX_W-1:0] i_cfg_index,
    input  wire [LEN_W-1:0]     i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int HIST_DEPTH = 1024;
    localparam int REPORT_MAX = 10;

    logic [COUNT_W-1:0] bin_counts [HIST_DEPTH];
    longint             plate_ref;
    logic [LEN_W-1:0]   box_len;
    logic [LEN_W-1:0]   bin_width;
    logic [BIN_W-1:0]   last_bin;
    t_out_item          due_results [$];

    initial begin
        foreach (bin_counts[k]) bin_counts[k] = '0;
        plate_ref    = 0;
        box_len      = BOX_LEN_RST;
        bin_width    = BIN_WIDTH_RST;
        last_bin     = LAST_BIN_RST;
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Updates the histogram state and returns the result beat the item should give
    function automatic t_out_item apply_item(input t_in_item it);
        t_out_item res;
        longint    first_z;
        longint    second_z;
        longint    offset;
        longint    quot;
        longint    bin;
        res = '0;
        case (it.operation)
            OP_SET_PLATE: begin
                first_z  = longint'($signed(it.plate_z_first));
                second_z = longint'($signed(it.plate_z_second));
                // one-sided: only first above second is rejected
                if (first_z > second_z) begin
                    res.status = ST_MISMATCH;
                end else begin
                    plate_ref  = first_z;
                    res.status = ST_OK;
                end
            end
            OP_SAMPLE: begin
                offset = longint'($signed(it.sample_z)) - plate_ref;
                if (offset < 0) offset += longint'(box_len);
                if (bin_width == '0) begin
                    res.status = ST_RANGE;
                end else begin
                    // truncates toward zero, so a small negative offset lands in bin 0
                    quot = ((offset < 0) ? -offset : offset) / longint'(bin_width);
                    bin  = (offset < 0) ? -quot : quot;
                    if (bin < 0 || bin > longint'(last_bin) || bin >= HIST_DEPTH) begin
                        res.status = ST_RANGE;
                    end else begin
                        if (bin_counts[bin] != '1) bin_counts[bin] += 1;
                        res.status    = ST_OK;
                        res.bin_out   = bin[BIN_W-1:0];
                        res.count_out = bin_counts[bin];
                    end
                end
            end
            OP_READ: begin
                res.status    = ST_READ;
                res.bin_out   = it.read_bin;
                res.count_out = bin_counts[it.read_bin];
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic flag_beat(input string what, input t_out_item want, input t_out_item got);
        o_fail_count++;
        if (o_fail_count <= REPORT_MAX)
            $display("%0t: %s: expected status %0d bin %0d count %0d, got status %0d bin %0d count %0d",
                     $realtime, what, want.status, want.bin_out, want.count_out,
                     got.status, got.bin_out, got.count_out);
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    flag_beat("result beat with nothing outstanding", '0, i_out_item);
                end else begin
                    want = due_results.pop_front();
                    if (want.status    != i_out_item.status  ||
                        want.bin_out   != i_out_item.bin_out ||
                        want.count_out != i_out_item.count_out)
                        flag_beat("result beat differs", want, i_out_item);
                end
            end
            if (i_in_valid && i_in_ready) due_results.push_back(apply_item(i_in_item));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BOX_LEN:   box_len   = i_cfg_data;
                    CFG_BIN_WIDTH: bin_width = i_cfg_data;
                    CFG_LAST_BIN:  last_bin  = i_cfg_data[BIN_W-1:0];
                    default: ;
                endcase
            end
            o_pending = due_results.size();
        end
    end

endmodule

>>> dv/tb_periodic_z_density_histogram.sv
`timescale 1ns / 1ps

module tb_periodic_z_density_histogram;
    import phz_pkg::*;

    localparam logic [OP_W-1:0]      OP_SPARE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
    localparam longint               COORD_MAX   = 8388607;
    localparam longint               COORD_MIN   = -8388608;
    localparam longint               LEN_MAX     = 8388607;
    localparam int                   HOLD_CYCLES = 120;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_in_item             in_item;
    logic                 out_valid;
    logic                 out_ready;
    t_out_item            out_item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;

    bit                   no_idle  = 1'b0;
    bit                   hold_req = 1'b0;
    // stimulus shaping only: last accepted plate and the current register values
    longint               plate_hint;
    logic [LEN_W-1:0]     cur_box;
    logic [LEN_W-1:0]     cur_width;
    logic [BIN_W-1:0]     cur_last;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    periodic_z_density_histogram u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    phz_density_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // unused fields carry noise
    function automatic t_in_item noisy_item(input logic [OP_W-1:0] op);
        t_in_item    it;
        logic [95:0] noise;
        noise        = {$urandom, $urandom, $urandom};
        it           = noise[$bits(t_in_item)-1:0];
        it.operation = op;
        return it;
    endfunction

    function automatic t_in_item plate_item(input longint first_z, input longint second_z);
        t_in_item it;
        it                = noisy_item(OP_SET_PLATE);
        it.plate_z_first  = first_z[COORD_W-1:0];
        it.plate_z_second = second_z[COORD_W-1:0];
        return it;
    endfunction

    function automatic t_in_item sample_item(input longint z);
        t_in_item it;
        it          = noisy_item(OP_SAMPLE);
        it.sample_z = z[COORD_W-1:0];
        return it;
    endfunction

    function automatic t_in_item read_item(input int idx);
        t_in_item it;
        it          = noisy_item(OP_READ);
        it.read_bin = idx[BIN_W-1:0];
        return it;
    endfunction

    function automatic t_in_item make_item();
        int     pick;
        longint first_z;
        longint span;
        longint offset;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            if ($urandom_range(0, 1) == 0) first_z = longint'($signed(24'($urandom)));
            else first_z = longint'($urandom_range(0, 2000)) - 1000;
            case ($urandom_range(0, 3))
                0, 1:    return plate_item(first_z, first_z);
                2:       return plate_item(first_z, first_z + $urandom_range(1, 1000));
                default: return plate_item(first_z, first_z - $urandom_range(1, 3));
            endcase
        end else if (pick < 62) begin
            if ($urandom_range(0, 4) == 0) return noisy_item(OP_SAMPLE);
            span = longint'(cur_width) * (longint'(cur_last) + 2);
            if (span > 16777216) span = 16777216;
            offset = longint'($urandom_range(0, span));
            // a third land below the plate and go through the wrap
            if ($urandom_range(0, 2) == 0) offset -= longint'(cur_box);
            return sample_item(plate_hint + offset);
        end else if (pick < 92) begin
            if ($urandom_range(0, 3) == 0) return read_item($urandom_range(0, 1023));
            return read_item($urandom_range(0, cur_last));
        end
        return noisy_item(OP_SPARE);
    endfunction

    task automatic send(input t_in_item it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  = it;
        in_valid = 1'b1;
        if (it.operation == OP_SET_PLATE &&
            $signed(it.plate_z_first) <= $signed(it.plate_z_second))
            plate_hint = longint'($signed(it.plate_z_first));
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) begin
            if (n != 0 && n % 30 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send(make_item());
        end
    endtask

    // block is idle once every result beat has been taken: each item gives one
    task automatic drain();
        in_valid = 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        case (idx)
            CFG_BOX_LEN:   cur_box   = data;
            CFG_BIN_WIDTH: cur_width = data;
            CFG_LAST_BIN:  cur_last  = data[BIN_W-1:0];
            default: ;
        endcase
    endtask

    // receiver: per-beat stall, plus one long hold-off on request
    initial begin : sink
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                out_ready = 1'b0;
                hold_req  = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (gap != 0) begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial begin : watchdog
        #300000;
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        int     last_pick;
        int     width_pick;
        longint box_pick;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_BOX_LEN;
        cfg_data   = '0;
        plate_hint = 0;
        cur_box    = BOX_LEN_RST;
        cur_width  = BIN_WIDTH_RST;
        cur_last   = LAST_BIN_RST;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings, plate at zero
        send(sample_item(0));
        send(sample_item(655 * 5 + 3));
        send(sample_item(-1));                    // wraps to the last bin
        send(sample_item(655 * 1001));            // just past last_bin
        send(sample_item(COORD_MAX));
        send(sample_item(COORD_MIN));             // still negative after the wrap
        send(plate_item(1, 0));                   // first above second by one LSB
        send(plate_item(COORD_MAX, COORD_MIN));
        send(plate_item(COORD_MIN, COORD_MAX));   // first below second is accepted
        send(sample_item(COORD_MIN + 655 * 7));
        send(sample_item(COORD_MAX));
        send(plate_item(-5, 9));
        send(plate_item(300, 300));
        send(sample_item(290));
        send(read_item(0));
        send(read_item(5));
        send(read_item(1000));
        send(read_item(1023));
        send(read_item(7));
        send(noisy_item(OP_SPARE));
        send(sample_item(300));
        drain();

        // smallest box, widest bin, single bin
        write_reg(CFG_BOX_LEN, 23'd1);
        write_reg(CFG_BIN_WIDTH, LEN_W'(LEN_MAX));
        write_reg(CFG_LAST_BIN, 23'd0);
        send(plate_item(COORD_MAX, COORD_MAX));
        send(sample_item(COORD_MAX - 100));       // small negative offset, bin 0
        send(sample_item(COORD_MIN));
        send(read_item(0));
        run_random(60);
        drain();

        // largest box, unit bins, full table; long receiver hold-off in here
        write_reg(CFG_BOX_LEN, LEN_W'(LEN_MAX));
        write_reg(CFG_BIN_WIDTH, 23'd1);
        write_reg(CFG_LAST_BIN, 23'd1023);
        run_random(20);
        no_idle  = 1'b1;
        hold_req = 1'b1;
        run_random(80);
        drain();

        // zero bin width; spare index and upper data bits are ignored
        write_reg(CFG_BIN_WIDTH, 23'd0);
        write_reg(CFG_SPARE, {LEN_W{1'b1}});
        write_reg(CFG_LAST_BIN, {13'h1FFF, 10'd1023});
        no_idle = 1'b0;
        run_random(30);
        drain();

        for (int p = 0; p < 3; p++) begin
            last_pick  = $urandom_range(0, 1023);
            width_pick = $urandom_range(1, 8191);
            box_pick   = longint'(width_pick) * (last_pick + 1) + $urandom_range(0, width_pick);
            if (box_pick > LEN_MAX) box_pick = LEN_MAX;
            write_reg(CFG_LAST_BIN, LEN_W'(last_pick));
            write_reg(CFG_BIN_WIDTH, LEN_W'(width_pick));
            write_reg(CFG_BOX_LEN, LEN_W'(box_pick));
            run_random(120);
            drain();
        end

        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
